[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers used by the rtl top
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/wlfo_pkg.sv]
// ----------------------------------------------------------------------------
// wlfo_pkg
// shared constants, codes and control types of the wavetable lfo
// ----------------------------------------------------------------------------
`default_nettype none

package wlfo_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int FRAC_BITS   = 16;
   localparam int PHASE_W     = ADDR_W + FRAC_BITS;
   localparam int LEN_W       = ADDR_W + 1;
   localparam int SPAN_W      = LEN_W + FRAC_BITS;
   localparam int RED_W       = SPAN_W + ADDR_W;
   localparam int RED_CNT_W   = $clog2(ADDR_W);

   localparam int SAMPLE_W    = 16;
   localparam int GAIN_W      = 16;
   localparam int OUT_W       = 16;
   localparam int PROD1_W     = SAMPLE_W + FRAC_BITS + 2;
   localparam int PROD2_W     = SAMPLE_W + GAIN_W + 2;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = PHASE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_INC  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEPTH_GAIN = 2'd2;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic [LEN_W-1:0]  LEN_RESET  = LEN_W'(TABLE_DEPTH);
   localparam logic [GAIN_W-1:0] GAIN_RESET = '1;

   typedef struct packed {
      logic                 write;
      logic                 reduce;
      logic [RED_CNT_W-1:0] shift;
      logic                 rd_lo;
      logic                 rd_hi;
      logic                 mul_diff;
      logic                 sum;
      logic                 scale;
      logic                 emit;
   } cmd_type;

   typedef struct packed {
      logic phase_over;
   } status_type;

endpackage

`default_nettype wire

[hw/rtl/wavetable_lfo_interp_top.sv]
// ----------------------------------------------------------------------------
// wavetable_lfo_interp_top
// wavetable lfo with linear interpolation, depth scaling and saturation
//
//   channel   direction  handshake           payload
//   req_      in         req_valid/stall     operation, entry_index, entry_value
//   rsp_      out        rsp_valid/stall     lfo_value
//   csr_      in         csr_write_en        csr_index, csr_write_data
//
// a table write gives no response
// a tick runs these steps one after another: accept, two reads of the
// single-port table, multiply, add, multiply and output
// after table_length is lowered below the phase, the next tick first reduces the phase
// wave table has no reset; phase and registers reset synchronously
// a held response does not block the next request; a tick waits at the end
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module wavetable_lfo_interp_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [wlfo_pkg::ADDR_W-1:0]          req_entry_index,
   input  logic signed [wlfo_pkg::SAMPLE_W-1:0] req_entry_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [wlfo_pkg::OUT_W-1:0]           rsp_lfo_value,
   input  logic                                 csr_write_en,
   input  logic [wlfo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [wlfo_pkg::CSR_DATA_W-1:0]      csr_write_data
);
   import wlfo_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       rsp_free;
   logic       tick_accept;
   logic       step_one_hot;

   wlfo_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .status        (status),
      .cmd           (cmd)
   );

   wlfo_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .rsp_lfo_value   (rsp_lfo_value)
   );

   assign rsp_free     = !rsp_valid || !rsp_stall;
   assign tick_accept  = req_valid && !req_stall && (req_operation == OP_TICK);
   assign step_one_hot = $onehot0({cmd.reduce, cmd.rd_lo, cmd.rd_hi, cmd.mul_diff, cmd.sum,
                                   cmd.scale, cmd.emit});

   `ASSERT_IMPLIES(a_emit_into_free, clock, reset, cmd.emit, rsp_free, "response overwritten")
   `ASSERT_IMPLIES(a_one_step, clock, reset, 1'b1, step_one_hot, "two datapath steps at once")
   `ASSERT_NEXT(a_tick_busy, clock, reset, tick_accept, req_stall, "busy not raised after tick")
   `ASSERT_IMPLIES(a_write_idle, clock, reset, cmd.write, !req_stall, "table written while busy")

endmodule

`default_nettype wire

[hw/rtl/wlfo_dpath.sv]
// ----------------------------------------------------------------------------
// wlfo_dpath
// registers, wave table, phase accumulator and interpolation arithmetic
// ----------------------------------------------------------------------------
`default_nettype none

module wlfo_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  wlfo_pkg::cmd_type                   cmd,
   output wlfo_pkg::status_type                status,
   input  logic [wlfo_pkg::ADDR_W-1:0]         req_entry_index,
   input  logic signed [wlfo_pkg::SAMPLE_W-1:0] req_entry_value,
   input  logic                                csr_write_en,
   input  logic [wlfo_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [wlfo_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic [wlfo_pkg::OUT_W-1:0]          rsp_lfo_value
);
   import wlfo_pkg::*;

   logic [PHASE_W-1:0]  inc_ff;
   logic [LEN_W-1:0]    len_ff;
   logic [GAIN_W-1:0]   gain_ff;
   logic [PHASE_W-1:0]  phase_ff;
   logic [PHASE_W-1:0]  phase_in;

   logic [SAMPLE_W-1:0] wave_mem_ff [TABLE_DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   rd_addr;

   logic [ADDR_W-1:0]   nxt_ff;
   logic [ADDR_W-1:0]   nxt_in;
   logic [FRAC_BITS-1:0] frac_ff;
   logic signed [SAMPLE_W-1:0] y0_ff;
   logic signed [PROD1_W-1:0]  prod1_ff;
   logic signed [PROD1_W-1:0]  prod1_in;
   logic signed [SAMPLE_W:0]   s_ff;
   logic signed [SAMPLE_W:0]   s_in;
   logic signed [PROD2_W-1:0]  prod2_ff;
   logic signed [PROD2_W-1:0]  prod2_in;
   logic [OUT_W-1:0]           out_ff;
   logic [OUT_W-1:0]           out_in;

   logic [LEN_W-1:0]    eff_len;
   logic [SPAN_W-1:0]   span;
   logic [RED_W-1:0]    red_span;
   logic [ADDR_W-1:0]   idx;
   logic [LEN_W-1:0]    idx_plus;
   logic [SPAN_W-1:0]   inc_eff;
   logic [SPAN_W-1:0]   phase_sum;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [PROD1_W-1:0]  interp_step;
   logic signed [PROD2_W-1:0]  v_wide;

   // effective length and span in phase units
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (len_ff > LEN_RESET) begin
         eff_len = LEN_RESET;
      end else begin
         eff_len = len_ff;
      end
      span = {eff_len, {FRAC_BITS{1'b0}}};
      status.phase_over = {1'b0, phase_ff} >= span;
   end

   always_comb begin
      idx      = phase_ff[PHASE_W-1:FRAC_BITS];
      idx_plus = {1'b0, idx} + LEN_W'(1);
      nxt_in   = (idx_plus >= eff_len) ? '0 : idx_plus[ADDR_W-1:0];
      rd_addr  = cmd.rd_hi ? nxt_ff : idx;
      red_span = RED_W'(span) << cmd.shift;
      inc_eff  = ({1'b0, inc_ff} >= span) ? span - SPAN_W'(1) : {1'b0, inc_ff};
      phase_sum = {1'b0, phase_ff} + inc_eff;
      phase_in = phase_ff;
      if (cmd.reduce) begin
         if (RED_W'(phase_ff) >= red_span) begin
            phase_in = phase_ff - red_span[PHASE_W-1:0];
         end
      end else if (cmd.rd_lo) begin
         if (phase_sum >= span) begin
            phase_in = PHASE_W'(phase_sum - span);
         end else begin
            phase_in = phase_sum[PHASE_W-1:0];
         end
      end
   end

   // interpolation and scaling arithmetic
   always_comb begin
      diff        = $signed({rd_data_ff[SAMPLE_W-1], rd_data_ff})
                  - $signed({y0_ff[SAMPLE_W-1], y0_ff});
      prod1_in    = PROD1_W'(diff) * $signed({{(PROD1_W-FRAC_BITS){1'b0}}, frac_ff});
      interp_step = prod1_ff >>> FRAC_BITS;
      s_in        = $signed({y0_ff[SAMPLE_W-1], y0_ff}) + interp_step[SAMPLE_W:0];
      prod2_in    = PROD2_W'(s_ff) * $signed({{(PROD2_W-GAIN_W){1'b0}}, gain_ff})
                  + PROD2_W'(1 << (GAIN_W - 1));
      v_wide      = (prod2_ff >>> GAIN_W) + PROD2_W'(1 << (OUT_W - 1));
      if (v_wide < 0) begin
         out_in = '0;
      end else if (v_wide > $signed(PROD2_W'({OUT_W{1'b1}}))) begin
         out_in = '1;
      end else begin
         out_in = v_wide[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inc_ff   <= '0;
         len_ff   <= LEN_RESET;
         gain_ff  <= GAIN_RESET;
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         if (csr_write_en) begin
            case (csr_index)
               CSR_PHASE_INC:  inc_ff  <= csr_write_data[PHASE_W-1:0];
               CSR_TABLE_LEN:  len_ff  <= csr_write_data[LEN_W-1:0];
               CSR_DEPTH_GAIN: gain_ff <= csr_write_data[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // single-port wave table, registered read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         wave_mem_ff[req_entry_index] <= req_entry_value;
      end
      rd_data_ff <= wave_mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_lo) begin
         nxt_ff  <= nxt_in;
         frac_ff <= phase_ff[FRAC_BITS-1:0];
      end
      if (cmd.rd_hi) begin
         y0_ff <= rd_data_ff;
      end
      if (cmd.mul_diff) begin
         prod1_ff <= prod1_in;
      end
      if (cmd.sum) begin
         s_ff <= s_in;
      end
      if (cmd.scale) begin
         prod2_ff <= prod2_in;
      end
      if (cmd.emit) begin
         out_ff <= out_in;
      end
   end

   assign rsp_lfo_value = out_ff;

endmodule

`default_nettype wire

[hw/rtl/wlfo_ctrl.sv]
// ----------------------------------------------------------------------------
// wlfo_ctrl
// sequencer for table writes, phase reduction and the tick computation
// ----------------------------------------------------------------------------
`default_nettype none

module wlfo_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  wlfo_pkg::status_type status,
   output wlfo_pkg::cmd_type    cmd
);
   import wlfo_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_RD_LO,
      ST_RD_HI,
      ST_MUL_DIFF,
      ST_SUM,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [RED_CNT_W-1:0] red_cnt_ff;
   logic                 rsp_valid_ff;
   logic                 accept;
   logic                 out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.write    = accept && (req_operation == OP_WRITE);
      cmd.reduce   = (state_ff == ST_REDUCE);
      cmd.shift    = red_cnt_ff;
      cmd.rd_lo    = (state_ff == ST_RD_LO);
      cmd.rd_hi    = (state_ff == ST_RD_HI);
      cmd.mul_diff = (state_ff == ST_MUL_DIFF);
      cmd.sum      = (state_ff == ST_SUM);
      cmd.scale    = (state_ff == ST_SCALE);
      cmd.emit     = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         red_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept && (req_operation == OP_TICK)) begin
                  if (status.phase_over) begin
                     red_cnt_ff <= RED_CNT_W'(ADDR_W - 1);
                     state_ff   <= ST_REDUCE;
                  end else begin
                     state_ff <= ST_RD_LO;
                  end
               end
            end
            ST_REDUCE: begin
               if (red_cnt_ff == '0) begin
                  state_ff <= ST_RD_LO;
               end else begin
                  red_cnt_ff <= red_cnt_ff - RED_CNT_W'(1);
               end
            end
            ST_RD_LO:    state_ff <= ST_RD_HI;
            ST_RD_HI:    state_ff <= ST_MUL_DIFF;
            ST_MUL_DIFF: state_ff <= ST_SUM;
            ST_SUM:      state_ff <= ST_SCALE;
            ST_SCALE:    state_ff <= ST_EMIT;
            ST_EMIT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
